### design/crs_pkg.sv
// Shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies; used by every module of the block but crs_ram and crs_fifo.
`timescale 1ns / 1ps

package crs_pkg;

	localparam int TFB          = 16;            // fraction bits of time
	localparam int U_W          = TFB + 1;       // u, u2, u3 in [0, 2^TFB]
	localparam int CNT_W        = 7;             // point_count register
	localparam int IDX_W        = 7;             // clamped indices stay below 127
	localparam int SLOT_W       = 6;
	localparam int SCALED_W     = U_W + CNT_W;
	localparam int SEG_W        = SCALED_W - TFB;
	localparam int COORD_W      = 24;
	localparam int PT_W         = 3 * COORD_W;
	localparam int W_W          = U_W + 4;       // doubled basis weights, signed
	localparam int PROD_W       = W_W + COORD_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int RES_W        = ACC_W - TFB - 1;
	localparam int MAX_POINTS_DEF = 64;
	localparam int MID_DEPTH    = 8;             // power of two
	localparam int OUT_DEPTH    = 8;             // power of two

	localparam logic [U_W-1:0] ONE  = U_W'(1) << TFB;
	localparam logic [U_W+U_W-1:0] HALF = (U_W+U_W)'(1) << (TFB - 1);
	localparam logic signed [RES_W-1:0] COORD_MAX = RES_W'(8388607);
	localparam logic signed [RES_W-1:0] COORD_MIN = -RES_W'(8388608);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic                      is_eval;
		logic                      wr_ok;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		idx_t [3:0]                idx;
		logic [U_W-1:0]            u;
		logic [U_W-1:0]            u2;
		logic [U_W-1:0]            u3;
	} mid_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      clipped;
	} out_item_t;

endpackage

### design/catmull_rom_spline_eval_core.sv
// Top level of the Catmull-Rom spline evaluator: front end, item queue,
// back end and result queue. Depends on crs_pkg, crs_fifo, crs_front, crs_back.
//
//  channel   handshake          payload
//  input     push / full        func, point_index, point_x/y/z, eval_time
//  result    empty / pop        out_x, out_y, out_z, clipped
//  config    cfg_we             cfg_wdata (point_count)
//
// One item per cycle sustained while full stays low; after its transfer an evaluate result
// passes the front stages, item queue, table read, 3 back stages and result queue.
// Throughput is set by the four replicated point tables, one read port each.
// Writes travel through the item queue, so table updates stay in item order.
// full rises when the item queue plus front stages hold MID_DEPTH items;
// evaluates wait in the item queue while the result queue has no credit.
// Reset clears control only; no clearing pass is needed.
`timescale 1ns / 1ps

module catmull_rom_spline_eval_core #(
	parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               func,
	input  logic [crs_pkg::SLOT_W-1:0]         point_index,
	input  logic signed [crs_pkg::COORD_W-1:0] point_x,
	input  logic signed [crs_pkg::COORD_W-1:0] point_y,
	input  logic signed [crs_pkg::COORD_W-1:0] point_z,
	input  logic [crs_pkg::U_W-1:0]            eval_time,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [crs_pkg::COORD_W-1:0] out_x,
	output logic signed [crs_pkg::COORD_W-1:0] out_y,
	output logic signed [crs_pkg::COORD_W-1:0] out_z,
	output logic                               clipped,
	input  logic                               cfg_we,
	input  logic [crs_pkg::CNT_W-1:0]          cfg_wdata
);

	logic [crs_pkg::CNT_W-1:0]                 point_count_q;
	logic                                      mid_push, mid_pop, mid_empty;
	crs_pkg::mid_item_t                        mid_in, mid_out;
	logic [$clog2(crs_pkg::MID_DEPTH+1)-1:0]   mid_count;
	logic                                      out_push, out_rd;
	crs_pkg::out_item_t                        out_in, out_head;
	logic [$clog2(crs_pkg::OUT_DEPTH+1)-1:0]   out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= crs_pkg::CNT_W'(2);
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	crs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.eval_time  (eval_time),
		.point_count(point_count_q),
		.mid_count  (mid_count),
		.mid_push   (mid_push),
		.mid_item   (mid_in)
	);

	crs_fifo #(
		.WIDTH($bits(crs_pkg::mid_item_t)),
		.DEPTH(crs_pkg::MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (mid_push),
		.din   (mid_in),
		.rd    (mid_pop),
		.dout  (mid_out),
		.empty (mid_empty),
		.count (mid_count)
	);

	crs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_item (mid_out),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_item (out_in)
	);

	assign out_rd = pop && !empty;

	crs_fifo #(
		.WIDTH($bits(crs_pkg::out_item_t)),
		.DEPTH(crs_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (out_push),
		.din   (out_in),
		.rd    (out_rd),
		.dout  (out_head),
		.empty (empty),
		.count (out_count)
	);

	assign out_x   = out_head.x;
	assign out_y   = out_head.y;
	assign out_z   = out_head.z;
	assign clipped = out_head.clipped;

endmodule

### design/crs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/crs_fifo.sv
// Small register FIFO with occupancy count; DEPTH must be a power of two.
// No dependencies.
`timescale 1ns / 1ps

module crs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [WIDTH-1:0]           din,
	input  logic                       rd,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PW'(1);
			end
			count_q <= count_q + CW'(wr) - CW'(rd);
		end
	end

	assign dout  = data_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

### design/crs_front.sv
// Front end: accepts items, scales time into segment and fraction, clamps the
// four point indices and forms u^2, u^3. Depends on crs_pkg.
`timescale 1ns / 1ps

module crs_front #(
	parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  func,
	input  logic [crs_pkg::SLOT_W-1:0]            point_index,
	input  logic signed [crs_pkg::COORD_W-1:0]    point_x,
	input  logic signed [crs_pkg::COORD_W-1:0]    point_y,
	input  logic signed [crs_pkg::COORD_W-1:0]    point_z,
	input  logic [crs_pkg::U_W-1:0]               eval_time,
	input  logic [crs_pkg::CNT_W-1:0]             point_count,
	input  logic [$clog2(crs_pkg::MID_DEPTH+1)-1:0] mid_count,
	output logic                                  mid_push,
	output crs_pkg::mid_item_t                    mid_item
);

	localparam int TFB = crs_pkg::TFB;
	localparam int UW  = crs_pkg::U_W;

	logic                             v_s1, v_s2, v_s3;
	logic                             take;
	logic [crs_pkg::CNT_W-1:0]        n_eff;
	logic [UW-1:0]                    t_sat;
	crs_pkg::mid_item_t               item_s1, item_s2, item_s3;
	crs_pkg::mid_item_t               s1_next, s2_next, s3_next;
	logic [crs_pkg::SCALED_W-1:0]     scaled_s1;
	logic [crs_pkg::CNT_W-1:0]        nm1_s1;
	logic [crs_pkg::SEG_W-1:0]        seg_raw, seg;
	logic [UW-1:0]                    u;
	logic [UW-1:0]                    u2;
	crs_pkg::idx_t [3:0]              idx;
	logic signed [crs_pkg::SEG_W+1:0] k_pos;
	logic [UW-1:0]                    u3;

	assign full = (32'(mid_count) + 32'(v_s1) + 32'(v_s2) + 32'(v_s3)) >= crs_pkg::MID_DEPTH;
	assign take = push && !full;

	// count 0 behaves as 1, counts beyond the table as the table size
	always_comb begin
		if (point_count == '0) begin
			n_eff = crs_pkg::CNT_W'(1);
		end else if (32'(point_count) > MAX_POINTS) begin
			n_eff = crs_pkg::CNT_W'(MAX_POINTS);
		end else begin
			n_eff = point_count;
		end
		t_sat = (eval_time > crs_pkg::ONE) ? crs_pkg::ONE : eval_time;
		s1_next         = '0;
		s1_next.is_eval = (func == crs_pkg::FUNC_EVAL);
		s1_next.wr_ok   = (32'(point_index) < MAX_POINTS);
		s1_next.slot    = point_index;
		s1_next.x       = point_x;
		s1_next.y       = point_y;
		s1_next.z       = point_z;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1   <= s1_next;
			scaled_s1 <= crs_pkg::SCALED_W'(t_sat) * crs_pkg::SCALED_W'(n_eff - 1'b1);
			nm1_s1    <= n_eff - 1'b1;
		end
	end

	// a whole scaled time above zero closes the previous segment at u = 1
	always_comb begin
		seg_raw = scaled_s1[crs_pkg::SCALED_W-1:TFB];
		if (scaled_s1[TFB-1:0] == '0 && seg_raw != '0) begin
			seg = seg_raw - 1'b1;
			u   = crs_pkg::ONE;
		end else begin
			seg = seg_raw;
			u   = {1'b0, scaled_s1[TFB-1:0]};
		end
		for (int k = 0; k < 4; k++) begin
			k_pos = $signed({2'b00, seg}) + (crs_pkg::SEG_W+2)'(k - 1);
			if (k_pos < 0) begin
				idx[k] = '0;
			end else if (k_pos > $signed({{(crs_pkg::SEG_W+2-crs_pkg::CNT_W){1'b0}}, nm1_s1})) begin
				idx[k] = nm1_s1;
			end else begin
				idx[k] = crs_pkg::IDX_W'(k_pos);
			end
		end
		u2 = UW'(((2*UW)'(u) * (2*UW)'(u) + crs_pkg::HALF) >> TFB);
		s2_next     = item_s1;
		s2_next.idx = idx;
		s2_next.u   = u;
		s2_next.u2  = u2;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			item_s2 <= s2_next;
		end
	end

	assign u3 = UW'(((2*UW)'(item_s2.u2) * (2*UW)'(item_s2.u) + crs_pkg::HALF) >> TFB);

	always_comb begin
		s3_next    = item_s2;
		s3_next.u3 = u3;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			item_s3 <= s3_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign mid_push = v_s3;
	assign mid_item = item_s3;

endmodule

### design/crs_back.sv
// Back end: applies point writes, reads four points from replicated tables,
// weights them with the Catmull-Rom basis, rounds and saturates.
// Depends on crs_pkg, crs_ram.
`timescale 1ns / 1ps

module crs_back #(
	parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    mid_empty,
	input  crs_pkg::mid_item_t                      mid_item,
	output logic                                    mid_pop,
	input  logic [$clog2(crs_pkg::OUT_DEPTH+1)-1:0] out_count,
	output logic                                    out_push,
	output crs_pkg::out_item_t                      out_item
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = crs_pkg::COORD_W;
	localparam int WW  = crs_pkg::W_W;
	localparam int PW  = crs_pkg::PROD_W;
	localparam int AC  = crs_pkg::ACC_W;
	localparam int RW  = crs_pkg::RES_W;

	logic                              issue, room, tbl_we;
	logic                              v_s1, v_s2, v_s3, v_s4;
	logic [crs_pkg::U_W-1:0]           u_s1, u2_s1, u3_s1;
	logic [crs_pkg::PT_W-1:0]          rdata [4];
	logic signed [WW-1:0]              su, su2, su3;
	logic signed [WW-1:0]              w [4];
	logic signed [WW-1:0]              w_s2 [4];
	logic signed [CW-1:0]              p_s2 [4][3];
	logic signed [PW-1:0]              prod_s3 [3][4];
	logic signed [AC-1:0]              acc_s4 [3];
	logic signed [AC-1:0]              rnd;
	logic signed [RW-1:0]              res;
	logic                              clip;

	// result credit: queued results plus those in flight must fit the output queue
	assign room   = (32'(out_count) + 32'(v_s1) + 32'(v_s2) + 32'(v_s3) + 32'(v_s4))
	                < crs_pkg::OUT_DEPTH;
	assign issue  = !mid_empty && (!mid_item.is_eval || room);
	assign mid_pop = issue;
	assign tbl_we = issue && !mid_item.is_eval && mid_item.wr_ok;

	for (genvar k = 0; k < 4; k++) begin : g_tbl
		crs_ram #(
			.WIDTH(crs_pkg::PT_W),
			.DEPTH(MAX_POINTS)
		) u_tbl (
			.clk  (clk),
			.we   (tbl_we),
			.waddr(AW'(mid_item.slot)),
			.wdata({mid_item.x, mid_item.y, mid_item.z}),
			.raddr(AW'(mid_item.idx[k])),
			.rdata(rdata[k])
		);
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			u_s1  <= mid_item.u;
			u2_s1 <= mid_item.u2;
			u3_s1 <= mid_item.u3;
		end
	end

	// doubled weights, exact at scale 2^TFB
	always_comb begin
		su   = $signed(WW'(u_s1));
		su2  = $signed(WW'(u2_s1));
		su3  = $signed(WW'(u3_s1));
		w[0] = -su3 + (su2 <<< 1) - su;
		w[1] = su3 + (su3 <<< 1) - su2 - (su2 <<< 2) + $signed(WW'(crs_pkg::ONE) <<< 1);
		w[2] = -su3 - (su3 <<< 1) + (su2 <<< 2) + su;
		w[3] = su3 - su2;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < 4; k++) begin
				w_s2[k]    <= w[k];
				p_s2[k][0] <= $signed(rdata[k][3*CW-1:2*CW]);
				p_s2[k][1] <= $signed(rdata[k][2*CW-1:CW]);
				p_s2[k][2] <= $signed(rdata[k][CW-1:0]);
			end
		end
		if (v_s2) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s3[c][k] <= PW'(w_s2[k]) * PW'(p_s2[k][c]);
				end
			end
		end
		if (v_s3) begin
			for (int c = 0; c < 3; c++) begin
				acc_s4[c] <= AC'(prod_s3[c][0]) + AC'(prod_s3[c][1])
				           + AC'(prod_s3[c][2]) + AC'(prod_s3[c][3]);
			end
		end
	end

	// round half up by floor((acc + 2^TFB) / 2^(TFB+1)), then saturate
	always_comb begin
		out_item = '0;
		clip     = 1'b0;
		for (int c = 0; c < 3; c++) begin
			rnd = acc_s4[c] + $signed(AC'(crs_pkg::ONE));
			res = RW'(rnd >>> (crs_pkg::TFB + 1));
			if (res > crs_pkg::COORD_MAX) begin
				res  = crs_pkg::COORD_MAX;
				clip = 1'b1;
			end else if (res < crs_pkg::COORD_MIN) begin
				res  = crs_pkg::COORD_MIN;
				clip = 1'b1;
			end
			case (c)
				0:       out_item.x = CW'(res);
				1:       out_item.y = CW'(res);
				default: out_item.z = CW'(res);
			endcase
		end
		out_item.clipped = clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue && mid_item.is_eval;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_push = v_s4;

endmodule

### design/crs_check.sv
// Port-level checks for catmull_rom_spline_eval_core, bound to the top level.
// Depends on crs_pkg.
`timescale 1ns / 1ps

module crs_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               push,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic signed [crs_pkg::COORD_W-1:0] out_x,
	input logic signed [crs_pkg::COORD_W-1:0] out_y,
	input logic signed [crs_pkg::COORD_W-1:0] out_z,
	input logic                               clipped
);

	localparam logic signed [crs_pkg::COORD_W-1:0] CMAX = crs_pkg::COORD_W'(8388607);
	localparam logic signed [crs_pkg::COORD_W-1:0] CMIN = -crs_pkg::COORD_W'(8388608);

	// a clipped result must carry at least one coordinate at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && clipped) |-> (out_x == CMAX || out_x == CMIN || out_y == CMAX ||
		                         out_y == CMIN || out_z == CMAX || out_z == CMIN))
		else $error("clipped result without a saturated coordinate");

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_x) && $stable(out_y) &&
		                      $stable(out_z) && $stable(clipped)))
		else $error("waiting result changed before transfer");

	// right out of reset both queues show idle
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> (empty && !full))
		else $error("queues not idle after reset");

endmodule

bind catmull_rom_spline_eval_core crs_check u_crs_check (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.out_x  (out_x),
	.out_y  (out_y),
	.out_z  (out_z),
	.clipped(clipped)
);

### verif/crs_checker.sv
// Checker for the Catmull-Rom spline evaluator: watches the input, config and result
// channels, predicts every evaluate result and compares it field by field.
// Depends on crs_pkg.
`timescale 1ns / 1ps

module crs_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               full,
	input  logic                               func,
	input  logic [crs_pkg::SLOT_W-1:0]         point_index,
	input  logic signed [crs_pkg::COORD_W-1:0] point_x,
	input  logic signed [crs_pkg::COORD_W-1:0] point_y,
	input  logic signed [crs_pkg::COORD_W-1:0] point_z,
	input  logic [crs_pkg::U_W-1:0]            eval_time,
	input  logic                               empty,
	input  logic                               pop,
	input  logic signed [crs_pkg::COORD_W-1:0] out_x,
	input  logic signed [crs_pkg::COORD_W-1:0] out_y,
	input  logic signed [crs_pkg::COORD_W-1:0] out_z,
	input  logic                               clipped,
	input  logic                               cfg_we,
	input  logic [crs_pkg::CNT_W-1:0]          cfg_wdata,
	output int                                 errors,
	output int                                 pending
);

	localparam int NPTS = 64;

	logic signed [crs_pkg::COORD_W-1:0] ctrl_pts [NPTS][3];
	logic [crs_pkg::CNT_W-1:0]          count_reg;
	crs_pkg::out_item_t                 curve_q [$];

	function automatic crs_pkg::out_item_t eval_curve(input logic [crs_pkg::U_W-1:0] t_in);
		longint n, t, scaled, seg, u, u2, u3, acc, r, k;
		longint w [4];
		int     ix [4];
		crs_pkg::out_item_t res;
		n = count_reg;
		if (n < 1) n = 1;
		if (n > NPTS) n = NPTS;
		t = t_in;
		if (t > 65536) t = 65536;
		scaled = t * (n - 1);
		seg = scaled >> crs_pkg::TFB;
		u = scaled & 65535;
		// whole scaled time closes the previous segment
		if (u == 0 && seg > 0) begin
			seg = seg - 1;
			u = 65536;
		end
		u2 = (u * u + 32768) >> crs_pkg::TFB;
		u3 = (u2 * u + 32768) >> crs_pkg::TFB;
		w[0] = -u3 + 2 * u2 - u;
		w[1] = 3 * u3 - 5 * u2 + 2 * 65536;
		w[2] = -3 * u3 + 4 * u2 + u;
		w[3] = u3 - u2;
		for (int j = 0; j < 4; j++) begin
			k = seg - 1 + j;
			if (k < 0) k = 0;
			if (k > n - 1) k = n - 1;
			ix[j] = int'(k);
		end
		res.clipped = 1'b0;
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int j = 0; j < 4; j++)
				acc += w[j] * longint'(ctrl_pts[ix[j]][c]);
			r = (acc + 65536) >>> (crs_pkg::TFB + 1);
			if (r > 8388607) begin
				r = 8388607;
				res.clipped = 1'b1;
			end else if (r < -8388608) begin
				r = -8388608;
				res.clipped = 1'b1;
			end
			case (c)
				0: res.x = r[crs_pkg::COORD_W-1:0];
				1: res.y = r[crs_pkg::COORD_W-1:0];
				default: res.z = r[crs_pkg::COORD_W-1:0];
			endcase
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crs_pkg::out_item_t want;
		if (!arst_n) begin
			count_reg <= crs_pkg::CNT_W'(2);
			errors <= 0;
			pending <= 0;
			curve_q.delete();
			for (int s = 0; s < NPTS; s++)
				for (int c = 0; c < 3; c++)
					ctrl_pts[s][c] <= '0;
		end else begin
			if (pop && !empty) begin
				if (curve_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing expected: %0d %0d %0d %b",
							$realtime, out_x, out_y, out_z, clipped);
					errors <= errors + 1;
				end else begin
					want = curve_q.pop_front();
					if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
						clipped !== want.clipped) begin
						if (errors < 10)
							$display("%0t: mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
								$realtime, want.x, want.y, want.z, want.clipped,
								out_x, out_y, out_z, clipped);
						errors <= errors + 1;
					end
				end
			end
			if (push && !full) begin
				if (func == crs_pkg::FUNC_WRITE) begin
					ctrl_pts[point_index][0] <= point_x;
					ctrl_pts[point_index][1] <= point_y;
					ctrl_pts[point_index][2] <= point_z;
				end else begin
					curve_q.push_back(eval_curve(eval_time));
				end
			end
			pending <= curve_q.size();
			if (cfg_we)
				count_reg <= cfg_wdata;
		end
	end

endmodule

### verif/tb_catmull_rom_spline_eval_core.sv
// Testbench top for the Catmull-Rom spline evaluator: clock, reset, stimulus with
// bursty pushes and patterned pops, verdict. Depends on crs_pkg, crs_checker, the core.
`timescale 1ns / 1ps

module tb_catmull_rom_spline_eval_core;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic func = crs_pkg::FUNC_WRITE;
	logic [crs_pkg::SLOT_W-1:0] point_index = '0;
	logic signed [crs_pkg::COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [crs_pkg::U_W-1:0] eval_time = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [crs_pkg::COORD_W-1:0] out_x, out_y, out_z;
	logic clipped;
	logic cfg_we = 1'b0;
	logic [crs_pkg::CNT_W-1:0] cfg_wdata = '0;
	int errors, pending;
	int cycles = 0;
	int burst_left = 0;
	int cur_count = 2;
	bit written [64];

	always #5 clk = ~clk;

	catmull_rom_spline_eval_core dut (
		.clk, .arst_n, .push, .full, .func, .point_index, .point_x, .point_y,
		.point_z, .eval_time, .empty, .pop, .out_x, .out_y, .out_z, .clipped,
		.cfg_we, .cfg_wdata
	);

	crs_checker chk (
		.clk, .arst_n, .push, .full, .func, .point_index, .point_x, .point_y,
		.point_z, .eval_time, .empty, .pop, .out_x, .out_y, .out_z, .clipped,
		.cfg_we, .cfg_wdata, .errors, .pending
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_catmull_rom_spline_eval_core: errors");
			$finish;
		end
	end

	// receiver: picks its stall mode at random among four patterns
	int pop_mode = 0;
	always @(posedge clk) begin
		if (cycles % 150 == 0)
			pop_mode <= $urandom_range(0, 3);
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 99) < 50);
			2: pop <= ($urandom_range(0, 99) < 10);
			default: pop <= ((cycles % 16) < 12);
		endcase
	end

	function automatic logic signed [crs_pkg::COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return crs_pkg::COORD_W'($urandom_range(0, 511)) - 24'sd256;
			default: return crs_pkg::COORD_W'($urandom());
		endcase
	endfunction

	// drive one transfer; push stays high afterwards only if more follow in the burst
	task automatic send_item(input logic f, input logic [crs_pkg::SLOT_W-1:0] slot,
		input logic [crs_pkg::U_W-1:0] t, input bit more);
		logic ok;
		push <= 1'b1;
		func <= f;
		point_index <= slot;
		point_x <= pick_coord();
		point_y <= pick_coord();
		point_z <= pick_coord();
		eval_time <= t;
		if (f == crs_pkg::FUNC_WRITE)
			written[slot] = 1'b1;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		if (burst_left > 0)
			burst_left--;
		if (!more || burst_left == 0) begin
			push <= 1'b0;
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			end
		end
	endtask

	task automatic set_count(input logic [crs_pkg::CNT_W-1:0] v);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= crs_pkg::CNT_W'($urandom());
		cur_count = (v == 0) ? 1 : (v > 64) ? 64 : v;
	endtask

	function automatic logic [crs_pkg::U_W-1:0] pick_time();
		int k;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return crs_pkg::ONE;
			2: return crs_pkg::U_W'($urandom_range(65537, 131071));
			3: begin
				// land on a segment boundary, or just off it
				k = $urandom_range(0, cur_count - 1);
				return crs_pkg::U_W'((k * 65536 + $urandom_range(0, cur_count - 2 + 1)) /
					((cur_count > 1) ? cur_count - 1 : 1));
			end
			default: return crs_pkg::U_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic random_phase(input int items);
		int lo;
		bit more;
		for (int i = 0; i < items; i++) begin
			more = (i != items - 1);
			lo = -1;
			for (int s = cur_count - 1; s >= 0; s--)
				if (!written[s]) lo = s;
			if (lo >= 0)
				send_item(crs_pkg::FUNC_WRITE, crs_pkg::SLOT_W'(lo),
					crs_pkg::U_W'($urandom()), more);
			else if ($urandom_range(0, 3) == 0)
				send_item(crs_pkg::FUNC_WRITE, crs_pkg::SLOT_W'($urandom_range(0, 63)),
					crs_pkg::U_W'($urandom()), more);
			else
				send_item(crs_pkg::FUNC_EVAL, crs_pkg::SLOT_W'($urandom()), pick_time(),
					more);
		end
	endtask

	initial begin
		logic [crs_pkg::CNT_W-1:0] cfgs [10] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd17,
			7'd3, 7'd2, 7'd100, 7'd33};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = 25;
		// directed: two points at reset count, time extremes
		send_item(crs_pkg::FUNC_WRITE, 6'd0, '0, 1);
		send_item(crs_pkg::FUNC_WRITE, 6'd1, '0, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, '0, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, crs_pkg::ONE, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, 17'h1FFFF, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, 17'h08000, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, 17'h00001, 1);
		send_item(crs_pkg::FUNC_WRITE, 6'd63, '0, 1);
		send_item(crs_pkg::FUNC_EVAL, '1, 17'h0FFFF, 0);
		set_count(7'd1);
		send_item(crs_pkg::FUNC_EVAL, '0, 17'h05555, 1);
		send_item(crs_pkg::FUNC_EVAL, '0, crs_pkg::ONE, 0);
		for (int p = 0; p < 10; p++) begin
			set_count(cfgs[p]);
			random_phase(90);
		end
		set_count(crs_pkg::CNT_W'($urandom_range(1, 64)));
		random_phase(40);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_catmull_rom_spline_eval_core: clean");
		else
			$display("tb_catmull_rom_spline_eval_core: errors");
		$finish;
	end

endmodule

### filelist.f
design/crs_pkg.sv
design/crs_ram.sv
design/crs_fifo.sv
design/crs_front.sv
design/crs_back.sv
design/catmull_rom_spline_eval_core.sv
design/crs_check.sv
verif/crs_checker.sv
verif/tb_catmull_rom_spline_eval_core.sv
